[hdl/grid_obstacle_inflation_top_defines.svh]
// Assertion macros shared by the grid obstacle inflation modules.
`ifndef GRID_OBSTACLE_INFLATION_TOP_DEFINES_SVH
`define GRID_OBSTACLE_INFLATION_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define GOI_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define GOI_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/goi_pkg.sv]
// Types, operation codes and the disc half-width table for the grid inflation block.
`timescale 1ns / 1ps

package goi_pkg;

    localparam int CELL_W  = 8;
    localparam int ROW_W   = 7;
    localparam int COL_W   = 7;
    localparam int OFF_W   = 5;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_INFLATE = 2'd1,
        OP_READ    = 2'd2,
        OP_NOP     = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_INFLATED  = 2'd1,
        CFG_SPARE2    = 2'd2,
        CFG_SPARE3    = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]        operation;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [CELL_W-1:0] cell_in;
    } in_word_t;

    typedef struct packed {
        logic [CELL_W-1:0] cell_out;
        logic              is_free;
        logic              inflate_done;
    } out_word_t;

    // HALF_WIDTH[r][d] = round(r*cos(d*pi/(2r))), ties away from zero
    localparam logic [3:0] HALF_WIDTH [16][16] = '{
        '{ 4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0, 4'd0, 4'd0,
           4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0, 4'd0, 4'd0},
        '{ 4'd1,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0, 4'd0, 4'd0,
           4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0, 4'd0, 4'd0},
        '{ 4'd2,  4'd1,  4'd0,  4'd0,  4'd0,  4'd0, 4'd0, 4'd0,
           4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0, 4'd0, 4'd0},
        '{ 4'd3,  4'd3,  4'd2,  4'd0,  4'd0,  4'd0, 4'd0, 4'd0,
           4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0, 4'd0, 4'd0},
        '{ 4'd4,  4'd4,  4'd3,  4'd2,  4'd0,  4'd0, 4'd0, 4'd0,
           4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0, 4'd0, 4'd0},
        '{ 4'd5,  4'd5,  4'd4,  4'd3,  4'd2,  4'd0, 4'd0, 4'd0,
           4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0, 4'd0, 4'd0},
        '{ 4'd6,  4'd6,  4'd5,  4'd4,  4'd3,  4'd2, 4'd0, 4'd0,
           4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0, 4'd0, 4'd0},
        '{ 4'd7,  4'd7,  4'd6,  4'd5,  4'd4,  4'd3, 4'd2, 4'd0,
           4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0, 4'd0, 4'd0},
        '{ 4'd8,  4'd8,  4'd7,  4'd7,  4'd6,  4'd4, 4'd3, 4'd2,
           4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0, 4'd0, 4'd0},
        '{ 4'd9,  4'd9,  4'd8,  4'd8,  4'd7,  4'd6, 4'd5, 4'd3,
           4'd2,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0, 4'd0, 4'd0},
        '{4'd10, 4'd10, 4'd10,  4'd9,  4'd8,  4'd7, 4'd6, 4'd5,
           4'd3,  4'd2,  4'd0,  4'd0,  4'd0,  4'd0, 4'd0, 4'd0},
        '{4'd11, 4'd11, 4'd11, 4'd10,  4'd9,  4'd8, 4'd7, 4'd6,
           4'd5,  4'd3,  4'd2,  4'd0,  4'd0,  4'd0, 4'd0, 4'd0},
        '{4'd12, 4'd12, 4'd12, 4'd11, 4'd10, 4'd10, 4'd8, 4'd7,
           4'd6,  4'd5,  4'd3,  4'd2,  4'd0,  4'd0, 4'd0, 4'd0},
        '{4'd13, 4'd13, 4'd13, 4'd12, 4'd12, 4'd11, 4'd10, 4'd9,
           4'd7,  4'd6,  4'd5,  4'd3,  4'd2,  4'd0, 4'd0, 4'd0},
        '{4'd14, 4'd14, 4'd14, 4'd13, 4'd13, 4'd12, 4'd11, 4'd10,
           4'd9,  4'd7,  4'd6,  4'd5,  4'd3,  4'd2, 4'd0, 4'd0},
        '{4'd15, 4'd15, 4'd15, 4'd14, 4'd14, 4'd13, 4'd12, 4'd11,
           4'd10, 4'd9,  4'd8,  4'd6,  4'd5,  4'd3, 4'd2, 4'd0}
    };

endpackage

[hdl/goi_grid_mem.sv]
// Grid cell store: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module goi_grid_mem #(
    parameter int DEPTH  = 16384,
    parameter int ADDR_W = 14
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [goi_pkg::CELL_W-1:0]  wr_data,
    input  logic                        rd_en,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [goi_pkg::CELL_W-1:0]  rd_data
);

    logic [goi_pkg::CELL_W-1:0] mem [DEPTH];
    logic [goi_pkg::CELL_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/goi_inflate_seq.sv]
// Inflation sequencer: row-major scan with read-modify-write of each disc neighbor.
`timescale 1ns / 1ps
`include "grid_obstacle_inflation_top_defines.svh"

module goi_inflate_seq #(
    parameter int GRID_ROWS = 128,
    parameter int GRID_COLS = 128,
    parameter int RADIUS    = 4,
    parameter int ADDR_W    = 14
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [goi_pkg::CELL_W-1:0]  threshold,
    input  logic [goi_pkg::CELL_W-1:0]  inflated,
    input  logic [goi_pkg::CELL_W-1:0]  rd_data,
    output logic                        rd_en,
    output logic [ADDR_W-1:0]           rd_addr,
    output logic                        wr_en,
    output logic [ADDR_W-1:0]           wr_addr,
    output logic [goi_pkg::CELL_W-1:0]  wr_data,
    output logic                        done
);

    localparam int R_W  = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int C_W  = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
    localparam int NR_W = R_W + 6;
    localparam int NC_W = C_W + 6;
    localparam int OW   = goi_pkg::OFF_W;
    localparam logic [3:0]          RAD   = 4'(RADIUS);
    localparam logic signed [OW-1:0] RAD_S = OW'(RADIUS);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_SCAN_RD  = 6'b000010,
        S_SCAN_CHK = 6'b000100,
        S_DISC_RD  = 6'b001000,
        S_DISC_WR  = 6'b010000,
        S_DONE     = 6'b100000
    } seq_state_t;

    seq_state_t             state_reg, state_next;
    logic [R_W-1:0]         r_reg, r_next;
    logic [C_W-1:0]         c_reg, c_next;
    logic signed [OW-1:0]   d_reg, d_next;
    logic signed [OW-1:0]   e_reg, e_next;
    logic [3:0]             h_reg, h_next;
    logic [ADDR_W-1:0]      nb_addr_reg, nb_addr_next;

    logic signed [NR_W-1:0] nr;
    logic signed [NC_W-1:0] nc;
    logic                   nb_inside;
    logic [ADDR_W-1:0]      center_addr;
    logic [ADDR_W-1:0]      nb_addr;
    logic                   last_cell;
    logic                   last_offset;
    logic signed [OW-1:0]   d_inc;
    logic [3:0]             h_inc;
    logic [3:0]             h_first;

    function automatic logic [3:0] abs_off(input logic signed [OW-1:0] v);
        logic signed [OW-1:0] m;
        m = -v;
        return v[OW-1] ? m[3:0] : v[3:0];
    endfunction

    assign nr = $signed({{(NR_W-R_W){1'b0}}, r_reg}) + NR_W'(d_reg);
    assign nc = $signed({{(NC_W-C_W){1'b0}}, c_reg}) + NC_W'(e_reg);
    assign nb_inside = !nr[NR_W-1] && (nr < $signed(NR_W'(GRID_ROWS)))
                    && !nc[NC_W-1] && (nc < $signed(NC_W'(GRID_COLS)));

    assign center_addr = ADDR_W'(32'(r_reg) * 32'(GRID_COLS) + 32'(c_reg));
    assign nb_addr = ADDR_W'(32'(nr[R_W-1:0]) * 32'(GRID_COLS) + 32'(nc[C_W-1:0]));

    assign last_cell   = (32'(r_reg) == 32'(GRID_ROWS - 1)) && (32'(c_reg) == 32'(GRID_COLS - 1));
    assign last_offset = (d_reg == RAD_S) && (e_reg == $signed({1'b0, h_reg}));
    assign d_inc       = d_reg + OW'(1);
    assign h_inc       = goi_pkg::HALF_WIDTH[RAD][abs_off(d_inc)];
    assign h_first     = goi_pkg::HALF_WIDTH[RAD][RAD];

    always_comb begin
        state_next   = state_reg;
        r_next       = r_reg;
        c_next       = c_reg;
        d_next       = d_reg;
        e_next       = e_reg;
        h_next       = h_reg;
        nb_addr_next = nb_addr_reg;
        rd_en        = 1'b0;
        rd_addr      = center_addr;
        wr_en        = 1'b0;
        done         = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    r_next     = '0;
                    c_next     = '0;
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                rd_en      = 1'b1;
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (rd_data >= threshold) begin
                    // start the disc at its top row
                    d_next     = -RAD_S;
                    h_next     = h_first;
                    e_next     = -$signed({1'b0, h_first});
                    state_next = S_DISC_RD;
                end else if (last_cell) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_SCAN_RD;
                end
            end
            S_DISC_RD: begin
                if (nb_inside) begin
                    rd_en        = 1'b1;
                    rd_addr      = nb_addr;
                    nb_addr_next = nb_addr;
                    state_next   = S_DISC_WR;
                end
            end
            S_DISC_WR: begin
                wr_en      = rd_data < threshold;
                state_next = S_DISC_RD;
            end
            S_DONE: begin
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // step to the next disc offset once the current one is handled, or finish the cell after the last
        if ((state_reg == S_DISC_WR) || ((state_reg == S_DISC_RD) && !nb_inside)) begin
            if (last_offset) begin
                state_next = last_cell ? S_DONE : S_SCAN_RD;
            end else if (e_reg == $signed({1'b0, h_reg})) begin
                d_next = d_inc;
                h_next = h_inc;
                e_next = -$signed({1'b0, h_inc});
            end else begin
                e_next = e_reg + OW'(1);
            end
        end

        // advance the scan position after a cell is finished
        if (state_next == S_SCAN_RD && (state_reg == S_SCAN_CHK || state_reg == S_DISC_RD
                                        || state_reg == S_DISC_WR)) begin
            if (32'(c_reg) == 32'(GRID_COLS - 1)) begin
                c_next = '0;
                r_next = r_reg + R_W'(1);
            end else begin
                c_next = c_reg + C_W'(1);
            end
        end
    end

    assign wr_addr = nb_addr_reg;
    assign wr_data = inflated;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        r_reg       <= r_next;
        c_reg       <= c_next;
        d_reg       <= d_next;
        e_reg       <= e_next;
        h_reg       <= h_next;
        nb_addr_reg <= nb_addr_next;
    end

    `GOI_ASSERT_SAME(a_rw_exclusive, aclk, aresetn, wr_en, !rd_en, "read and write in one cycle")
    `GOI_ASSERT_SAME(a_wr_after_rd, aclk, aresetn, wr_en, $past(rd_en) && ($past(rd_addr) == wr_addr), "write without its read")
    `GOI_ASSERT_NEXT(a_start_idle, aclk, aresetn, start && (state_reg == S_IDLE), state_reg == S_SCAN_RD, "scan did not start")

endmodule

[hdl/grid_obstacle_inflation_top.sv]
// Top level of the occupancy grid obstacle inflation block.
//
//  port group      dir   handshake              carries
//  s_*             in    s_valid / s_ready      in_word_t: operation, row, col, cell_in
//  m_*             out   m_valid / m_ready      out_word_t: cell_out, is_free, inflate_done
//  cfg_*           in    cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// Load, no-op and out-of-grid read words go straight to the result register; an in-grid
// read passes the memory read register and ST_READ. Inflate scans each cell, then, using
// the single memory read/write pair, rewrites the in-grid disc cells below threshold.
// Reset clears control and loads register defaults; grid cells are undefined until loaded.
// A stalled m_ready holds the result register and blocks the next input word.
`timescale 1ns / 1ps
`include "grid_obstacle_inflation_top_defines.svh"

module grid_obstacle_inflation_top #(
    parameter int GRID_ROWS = 128,
    parameter int GRID_COLS = 128,
    parameter int RADIUS    = 4
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  goi_pkg::in_word_t                 s_word,
    output logic                              m_valid,
    input  logic                              m_ready,
    output goi_pkg::out_word_t                m_word,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [goi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [goi_pkg::CELL_W-1:0]        cfg_data
);

    localparam int DEPTH  = GRID_ROWS * GRID_COLS;
    localparam int ADDR_W = $clog2(DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_INFL = 3'b100
    } top_state_t;

    top_state_t                 state_reg, state_next;
    logic                       m_valid_reg, m_valid_next;
    goi_pkg::out_word_t         m_word_reg, m_word_next;
    logic [goi_pkg::CELL_W-1:0] thr_reg;
    logic [goi_pkg::CELL_W-1:0] infl_reg;

    logic                       s_accept;
    logic                       in_grid;
    logic [ADDR_W-1:0]          s_addr;

    logic                       mem_wr_en, mem_rd_en;
    logic [ADDR_W-1:0]          mem_wr_addr, mem_rd_addr;
    logic [goi_pkg::CELL_W-1:0] mem_wr_data, mem_rd_data;

    logic                       ld_wr_en, ld_rd_en;
    logic                       seq_start, seq_done;
    logic                       seq_rd_en, seq_wr_en;
    logic [ADDR_W-1:0]          seq_rd_addr, seq_wr_addr;
    logic [goi_pkg::CELL_W-1:0] seq_wr_data;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign s_accept  = s_valid && s_ready;
    assign in_grid   = (32'(s_word.row) < 32'(GRID_ROWS)) && (32'(s_word.col) < 32'(GRID_COLS));
    assign s_addr    = ADDR_W'(32'(s_word.row) * 32'(GRID_COLS) + 32'(s_word.col));

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        m_word_next  = m_word_reg;
        ld_wr_en     = 1'b0;
        ld_rd_en     = 1'b0;
        seq_start    = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    m_word_next = '0;
                    unique case (goi_pkg::op_t'(s_word.operation))
                        goi_pkg::OP_LOAD: begin
                            ld_wr_en     = in_grid;
                            m_valid_next = 1'b1;
                            if (in_grid) begin
                                m_word_next.cell_out = s_word.cell_in;
                            end
                        end
                        goi_pkg::OP_INFLATE: begin
                            seq_start  = 1'b1;
                            state_next = ST_INFL;
                        end
                        goi_pkg::OP_READ: begin
                            if (in_grid) begin
                                ld_rd_en   = 1'b1;
                                state_next = ST_READ;
                            end else begin
                                m_valid_next = 1'b1;
                            end
                        end
                        goi_pkg::OP_NOP: begin
                            m_valid_next = 1'b1;
                        end
                        default: begin
                            m_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                // result slot was free at accept, so load it now
                m_word_next.cell_out     = mem_rd_data;
                m_word_next.is_free      = mem_rd_data < infl_reg;
                m_word_next.inflate_done = 1'b0;
                m_valid_next             = 1'b1;
                state_next               = ST_IDLE;
            end
            ST_INFL: begin
                if (seq_done) begin
                    m_word_next              = '0;
                    m_word_next.inflate_done = 1'b1;
                    m_valid_next             = 1'b1;
                    state_next               = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // hand the memory ports to the sequencer while it walks the grid
    always_comb begin
        if (state_reg == ST_INFL) begin
            mem_wr_en   = seq_wr_en;
            mem_wr_addr = seq_wr_addr;
            mem_wr_data = seq_wr_data;
            mem_rd_en   = seq_rd_en;
            mem_rd_addr = seq_rd_addr;
        end else begin
            mem_wr_en   = ld_wr_en;
            mem_wr_addr = s_addr;
            mem_wr_data = s_word.cell_in;
            mem_rd_en   = ld_rd_en;
            mem_rd_addr = s_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            thr_reg     <= 8'd192;
            infl_reg    <= 8'd128;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                unique case (goi_pkg::cfg_idx_t'(cfg_index))
                    goi_pkg::CFG_THRESHOLD: thr_reg  <= cfg_data;
                    goi_pkg::CFG_INFLATED:  infl_reg <= cfg_data;
                    goi_pkg::CFG_SPARE2:    thr_reg  <= thr_reg;
                    goi_pkg::CFG_SPARE3:    infl_reg <= infl_reg;
                    default:                thr_reg  <= thr_reg;
                endcase
            end
        end
        m_word_reg <= m_word_next;
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

    goi_grid_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_grid_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    goi_inflate_seq #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS),
        .RADIUS    (RADIUS),
        .ADDR_W    (ADDR_W)
    ) u_inflate_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (seq_start),
        .threshold (thr_reg),
        .inflated  (infl_reg),
        .rd_data   (mem_rd_data),
        .rd_en     (seq_rd_en),
        .rd_addr   (seq_rd_addr),
        .wr_en     (seq_wr_en),
        .wr_addr   (seq_wr_addr),
        .wr_data   (seq_wr_data),
        .done      (seq_done)
    );

    `GOI_ASSERT_SAME(a_busy_not_ready, aclk, aresetn, state_reg != ST_IDLE, !s_ready, "input taken while busy")
    `GOI_ASSERT_NEXT(a_read_result, aclk, aresetn, state_reg == ST_READ, m_valid && !m_word.inflate_done, "read result missing")
    `GOI_ASSERT_SAME(a_done_in_infl, aclk, aresetn, seq_done, state_reg == ST_INFL, "walk finished outside inflate")

endmodule
